// ===== rtl/software_timer_scheduler_unit_defines.svh =====
// Assertion helpers shared by the timer scheduler RTL.
`ifndef SOFTWARE_TIMER_SCHEDULER_UNIT_DEFINES_SVH
`define SOFTWARE_TIMER_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define STSU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STSU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stsu_pkg.sv =====
package stsu_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ADD       = 2'd0,
    KIND_REMOVE    = 2'd1,
    KIND_EXPIRED   = 2'd2,
    KIND_IDLE_TICK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ADD,
    CELL_REMOVE,
    CELL_TICK,
    CELL_SCAN,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       sort_en;
    logic       odd_phase;
    logic       stat_load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] duration;
    logic        repeating;
    logic [31:0] target_ident;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] timer_ref;
    logic        ok;
    logic        last;
    logic [4:0]  active_count;
    logic [23:0] time_to_next;
  } result_t;

endpackage

// ===== rtl/stsu_cell.sv =====
module stsu_cell #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32,
  parameter int INDEX     = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stsu_pkg::cell_ctrl_t      ctrl,
  input  logic [TIME_BITS-1:0]      now,
  input  logic                      add_sel,
  input  logic [23:0]               add_dur,
  input  logic                      add_rep,
  input  logic [31:0]               add_ident,
  input  logic [31:0]               target,
  input  logic                      l_due,
  input  logic [TIME_BITS-1:0]      l_age,
  input  logic [31:0]               l_ident,
  input  logic [$clog2(SLOTS)-1:0]  l_slot,
  input  logic                      r_due_in,
  input  logic [TIME_BITS-1:0]      r_age_in,
  input  logic [31:0]               r_ident_in,
  input  logic [$clog2(SLOTS)-1:0]  r_slot_in,
  input  logic                      rs_valid,
  input  logic                      rs_zero,
  input  logic [23:0]               rs_d,
  output logic                      valid,
  output logic                      hit,
  output logic                      rec_due,
  output logic [TIME_BITS-1:0]      rec_age,
  output logic [31:0]               rec_ident,
  output logic [$clog2(SLOTS)-1:0]  rec_slot,
  output logic                      st_valid,
  output logic                      st_zero,
  output logic [23:0]               st_d
);

  localparam int IW = $clog2(SLOTS);
  localparam logic PAR = 1'(INDEX % 2);
  localparam logic [IW-1:0] MY_SLOT = IW'(INDEX);
  localparam bit HAS_LEFT = INDEX > 0;
  localparam bit HAS_RIGHT = INDEX < SLOTS - 1;

  logic [TIME_BITS-1:0] expiry;
  logic [23:0]          period;
  logic                 periodic;
  logic [31:0]          ident;

  logic [TIME_BITS-1:0] age;
  logic [TIME_BITS-1:0] left_d;
  logic                 due;
  logic                 take_right;
  logic                 take_left;

  // Strict emission order: due first, older first, then lower ident, then lower slot.
  function automatic logic ahead(
    input logic adue, input logic [TIME_BITS-1:0] aage,
    input logic [31:0] aid, input logic [IW-1:0] aslot,
    input logic bdue, input logic [TIME_BITS-1:0] bage,
    input logic [31:0] bid, input logic [IW-1:0] bslot);
    logic res;
    if (adue != bdue) res = adue;
    else if (!adue) res = 1'b0;
    else if (aage != bage) res = aage > bage;
    else if (aid != bid) res = aid < bid;
    else res = aslot < bslot;
    return res;
  endfunction

  assign age    = now - expiry;
  assign left_d = expiry - now;
  assign due    = valid && !age[TIME_BITS-1];
  assign hit    = valid && (ident == target);

  // swap with the partner when the right record of the pair is ahead of the left one
  always_comb begin
    take_right = 1'b0;
    take_left  = 1'b0;
    if (HAS_RIGHT && ctrl.odd_phase == PAR) begin
      take_right = ahead(r_due_in, r_age_in, r_ident_in, r_slot_in,
                         rec_due, rec_age, rec_ident, rec_slot);
    end
    if (HAS_LEFT && ctrl.odd_phase != PAR) begin
      take_left = ahead(rec_due, rec_age, rec_ident, rec_slot,
                        l_due, l_age, l_ident, l_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.mode)
        stsu_pkg::CELL_ADD: begin
          if (add_sel) begin
            valid <= 1'b1;
          end
        end
        stsu_pkg::CELL_REMOVE: begin
          if (hit) begin
            valid <= 1'b0;
          end
        end
        stsu_pkg::CELL_TICK: begin
          if (due && !periodic) begin
            valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      stsu_pkg::CELL_ADD: begin
        if (add_sel) begin
          expiry   <= now + {{(TIME_BITS-24){1'b0}}, add_dur};
          period   <= add_dur;
          periodic <= add_rep;
          ident    <= add_ident;
        end
      end
      stsu_pkg::CELL_TICK: begin
        rec_due   <= due;
        rec_age   <= age;
        rec_ident <= ident;
        rec_slot  <= MY_SLOT;
        // re-arm from the new time; age above still uses the old expiry
        if (due && periodic) begin
          expiry <= now + {{(TIME_BITS-24){1'b0}}, period};
        end
      end
      stsu_pkg::CELL_SCAN: begin
        if (ctrl.sort_en) begin
          if (take_right) begin
            rec_due   <= r_due_in;
            rec_age   <= r_age_in;
            rec_ident <= r_ident_in;
            rec_slot  <= r_slot_in;
          end else if (take_left) begin
            rec_due   <= l_due;
            rec_age   <= l_age;
            rec_ident <= l_ident;
            rec_slot  <= l_slot;
          end
        end
        if (ctrl.stat_load) begin
          st_valid <= valid;
          st_zero  <= (left_d == '0) || left_d[TIME_BITS-1];
          st_d     <= (|left_d[TIME_BITS-1:24]) ? 24'hFFFFFF : left_d[23:0];
        end else begin
          st_valid <= rs_valid;
          st_zero  <= rs_zero;
          st_d     <= rs_d;
        end
      end
      stsu_pkg::CELL_SHIFT: begin
        rec_due   <= r_due_in;
        rec_age   <= r_age_in;
        rec_ident <= r_ident_in;
        rec_slot  <= r_slot_in;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/software_timer_scheduler_unit.sv =====
// Timer table, a row of SLOTS timer cells, with a clock that each tick item advances.
// Input: an item (add, remove or tick) transfers when start is high and busy is low.
// busy falls in the cycle that shows the last result of an item, so the next item
// may transfer in that cycle.
// Output: each result sits on result for one cycle with done high; result.last
// marks the final one of an item. The receiver cannot stall; nothing is held.
// Steps per item: after the transfer the cells are updated, then an odd-even
// transposition sort runs over the row while the status lane shifts the
// per-cell counts and times into an accumulator at cell 0.
// Results follow: one for add or remove, and for a tick one per expired timer
// (at least one), each shifted out of cell 0 and shown on result in the next cycle.
// The next item cannot transfer until the last result of the current one shows.
// Command code 3 transfers but does nothing and keeps busy low.
// Reset (rst, synchronous) frees all slots, zeroes the clock, sets the next
// identifier to 1 and returns to idle.
`include "software_timer_scheduler_unit_defines.svh"

module software_timer_scheduler_unit #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  stsu_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output stsu_pkg::result_t result
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] CNT_END = CW'(SLOTS);

  stsu_pkg::state_t     state;
  stsu_pkg::state_t     state_next;
  stsu_pkg::cell_ctrl_t ctrl;

  logic [1:0]           cmd_r;
  logic [23:0]          dur_r;
  logic                 rep_r;
  logic [31:0]          target_r;
  logic [TIME_BITS-1:0] now;
  logic [31:0]          next_ident;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        acc_cnt;
  logic                 acc_zero;
  logic                 acc_any;
  logic [23:0]          acc_min;
  logic                 add_ok;
  logic [31:0]          add_ref;
  logic                 rem_ok;

  logic [SLOTS-1:0]     cell_valid;
  logic [SLOTS-1:0]     cell_hit;
  logic [SLOTS-1:0]     add_sel;
  logic                 free_found;

  logic                 rec_due   [SLOTS];
  logic [TIME_BITS-1:0] rec_age   [SLOTS];
  logic [31:0]          rec_ident [SLOTS];
  logic [IW-1:0]        rec_slot  [SLOTS];
  logic                 st_valid  [SLOTS];
  logic                 st_zero   [SLOTS];
  logic [23:0]          st_d      [SLOTS];

  logic                 fire;
  stsu_pkg::result_t    res_c;
  logic [CW+4:0]        cnt_ext;

  // lowest free slot as a one-hot select
  always_comb begin
    free_found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      add_sel[i] = !cell_valid[i] && !free_found;
      free_found = free_found || !cell_valid[i];
    end
  end

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      logic                 ld;
      logic [TIME_BITS-1:0] la;
      logic [31:0]          li;
      logic [IW-1:0]        ls;
      logic                 rd;
      logic [TIME_BITS-1:0] ra;
      logic [31:0]          ri;
      logic [IW-1:0]        rsl;
      logic                 sv;
      logic                 sz;
      logic [23:0]          sd;

      if (g > 0) begin : g_left
        assign ld = rec_due[g-1];
        assign la = rec_age[g-1];
        assign li = rec_ident[g-1];
        assign ls = rec_slot[g-1];
      end else begin : g_left_end
        assign ld = 1'b0;
        assign la = '0;
        assign li = '0;
        assign ls = '0;
      end

      if (g < SLOTS - 1) begin : g_right
        assign rd  = rec_due[g+1];
        assign ra  = rec_age[g+1];
        assign ri  = rec_ident[g+1];
        assign rsl = rec_slot[g+1];
        assign sv  = st_valid[g+1];
        assign sz  = st_zero[g+1];
        assign sd  = st_d[g+1];
      end else begin : g_right_end
        assign rd  = 1'b0;
        assign ra  = '0;
        assign ri  = '0;
        assign rsl = '0;
        assign sv  = 1'b0;
        assign sz  = 1'b0;
        assign sd  = '0;
      end

      stsu_cell #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS),
        .INDEX     (g)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .now        (now),
        .add_sel    (add_sel[g]),
        .add_dur    (dur_r),
        .add_rep    (rep_r),
        .add_ident  (next_ident),
        .target     (target_r),
        .l_due      (ld),
        .l_age      (la),
        .l_ident    (li),
        .l_slot     (ls),
        .r_due_in   (rd),
        .r_age_in   (ra),
        .r_ident_in (ri),
        .r_slot_in  (rsl),
        .rs_valid   (sv),
        .rs_zero    (sz),
        .rs_d       (sd),
        .valid      (cell_valid[g]),
        .hit        (cell_hit[g]),
        .rec_due    (rec_due[g]),
        .rec_age    (rec_age[g]),
        .rec_ident  (rec_ident[g]),
        .rec_slot   (rec_slot[g]),
        .st_valid   (st_valid[g]),
        .st_zero    (st_zero[g]),
        .st_d       (st_d[g])
      );
    end
  endgenerate

  assign busy = state != stsu_pkg::ST_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      stsu_pkg::ST_IDLE: begin
        if (start && item.cmd != stsu_pkg::CMD_NONE) begin
          state_next = stsu_pkg::ST_APPLY;
        end
      end
      stsu_pkg::ST_APPLY: state_next = stsu_pkg::ST_SCAN;
      stsu_pkg::ST_SCAN: begin
        if (cnt == CNT_END) begin
          state_next = stsu_pkg::ST_EMIT;
        end
      end
      stsu_pkg::ST_EMIT: begin
        if (cmd_r != stsu_pkg::CMD_TICK || !rec_due[0] || !rec_due[1]) begin
          state_next = stsu_pkg::ST_IDLE;
        end
      end
      default: state_next = stsu_pkg::ST_IDLE;
    endcase
  end

  assign cnt_ext = {5'd0, acc_cnt};

  always_comb begin
    ctrl.mode      = stsu_pkg::CELL_HOLD;
    ctrl.sort_en   = cnt < CNT_END;
    ctrl.odd_phase = cnt[0];
    ctrl.stat_load = cnt == '0;
    fire           = 1'b0;
    res_c.kind         = stsu_pkg::KIND_ADD;
    res_c.timer_ref    = '0;
    res_c.ok           = 1'b0;
    res_c.last         = 1'b1;
    res_c.active_count = cnt_ext[4:0];
    res_c.time_to_next = (!acc_any || acc_zero) ? 24'd0 : acc_min;
    unique case (state)
      stsu_pkg::ST_APPLY: begin
        unique case (cmd_r)
          stsu_pkg::CMD_ADD:    ctrl.mode = stsu_pkg::CELL_ADD;
          stsu_pkg::CMD_REMOVE: ctrl.mode = stsu_pkg::CELL_REMOVE;
          stsu_pkg::CMD_TICK:   ctrl.mode = stsu_pkg::CELL_TICK;
          default:              ctrl.mode = stsu_pkg::CELL_HOLD;
        endcase
      end
      stsu_pkg::ST_SCAN: ctrl.mode = stsu_pkg::CELL_SCAN;
      stsu_pkg::ST_EMIT: begin
        fire = 1'b1;
        unique case (cmd_r)
          stsu_pkg::CMD_ADD: begin
            res_c.kind      = stsu_pkg::KIND_ADD;
            res_c.timer_ref = add_ref;
            res_c.ok        = add_ok;
          end
          stsu_pkg::CMD_REMOVE: begin
            res_c.kind = stsu_pkg::KIND_REMOVE;
            res_c.ok   = rem_ok;
          end
          default: begin
            if (rec_due[0]) begin
              // sorted row: pop the head and advance the rest
              ctrl.mode       = stsu_pkg::CELL_SHIFT;
              res_c.kind      = stsu_pkg::KIND_EXPIRED;
              res_c.timer_ref = rec_ident[0];
              res_c.last      = !rec_due[1];
            end else begin
              res_c.kind = stsu_pkg::KIND_IDLE_TICK;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= stsu_pkg::ST_IDLE;
      now        <= '0;
      next_ident <= 32'd1;
      cnt        <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fire;
      if (state == stsu_pkg::ST_IDLE && start && item.cmd == stsu_pkg::CMD_TICK) begin
        now <= now + {{(TIME_BITS-1){1'b0}}, 1'b1};
      end
      if (state == stsu_pkg::ST_APPLY) begin
        cnt <= '0;
        if (cmd_r == stsu_pkg::CMD_ADD && free_found) begin
          next_ident <= next_ident + 32'd1;
        end
      end else if (state == stsu_pkg::ST_SCAN) begin
        cnt <= cnt + {{(CW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= res_c;
    if (state == stsu_pkg::ST_IDLE && start) begin
      cmd_r    <= item.cmd;
      dur_r    <= item.duration;
      rep_r    <= item.repeating;
      target_r <= item.target_ident;
    end
    if (state == stsu_pkg::ST_APPLY) begin
      add_ok  <= free_found;
      add_ref <= free_found ? next_ident : 32'd0;
      rem_ok  <= |cell_hit;
    end
    if (state == stsu_pkg::ST_SCAN) begin
      if (cnt == '0) begin
        acc_cnt  <= '0;
        acc_any  <= 1'b0;
        acc_zero <= 1'b0;
        acc_min  <= 24'hFFFFFF;
      end else if (st_valid[0]) begin
        // fold the status record at the head of the lane
        acc_cnt  <= acc_cnt + {{(CW-1){1'b0}}, 1'b1};
        acc_any  <= 1'b1;
        acc_zero <= acc_zero || st_zero[0];
        if (st_d[0] < acc_min) begin
          acc_min <= st_d[0];
        end
      end
    end
  end

  `STSU_ASSERT_NXT(a_busy_after_start, clk, rst,
    start && !busy && item.cmd != stsu_pkg::CMD_NONE, busy, "busy not raised")
  `STSU_ASSERT_IMP(a_done_from_emit, clk, rst,
    done, $past(state) == stsu_pkg::ST_EMIT, "result without emit")
  `STSU_ASSERT_IMP(a_last_frees, clk, rst,
    done && result.last, !busy, "still busy after last result")
  `STSU_ASSERT_IMP(a_idle_tick_last, clk, rst,
    done && result.kind == stsu_pkg::KIND_IDLE_TICK, result.last, "idle tick not last")

endmodule

// ===== tb/software_timer_scheduler_unit_test.sv =====
module software_timer_scheduler_unit_test;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  stsu_pkg::item_t   item = '0;
  logic              busy;
  logic              done;
  stsu_pkg::result_t result;

  software_timer_scheduler_unit u_top (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  always #4 clk = ~clk;

  // predictor copy of the timer table
  logic        tbl_valid [SLOTS];
  logic [31:0] tbl_expiry [SLOTS];
  logic [23:0] tbl_period [SLOTS];
  logic        tbl_periodic [SLOTS];
  logic [31:0] tbl_ident [SLOTS];
  logic [31:0] tick_now;
  logic [31:0] ident_next;

  stsu_pkg::item_t   pending_items [$];
  stsu_pkg::result_t expected_results [$];
  int      fail_count = 0;
  int      idle_cycles = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      expiries_seen = 0;
  bit      calm = 1'b0;
  bit      stim_done = 1'b0;

  function automatic logic [23:0] ticks_left();
    logic [31:0] d;
    logic [31:0] best;
    bit          any;
    best = '0;
    any = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) begin
        d = tbl_expiry[i] - tick_now;
        if (d == 0 || d[31]) return '0;
        if (!any || d < best) begin
          best = d;
          any = 1'b1;
        end
      end
    end
    if (!any) return '0;
    return (best > 32'hFFFFFF) ? 24'hFFFFFF : best[23:0];
  endfunction

  task automatic predict_timers(input stsu_pkg::item_t it);
    stsu_pkg::result_t r;
    stsu_pkg::result_t outs [$];
    int          free_slot;
    int          pick;
    bit          found;
    bit          due [SLOTS];
    logic [31:0] age [SLOTS];
    logic [4:0]  act;
    logic [23:0] ttn;
    r = '0;
    case (it.cmd)
      stsu_pkg::CMD_ADD: begin
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!tbl_valid[i] && free_slot < 0) free_slot = i;
        r.kind = stsu_pkg::KIND_ADD;
        r.last = 1'b1;
        if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_expiry[free_slot] = tick_now + 32'(it.duration);
          tbl_period[free_slot] = it.duration;
          tbl_periodic[free_slot] = it.repeating;
          tbl_ident[free_slot] = ident_next;
          r.timer_ref = ident_next;
          r.ok = 1'b1;
          ident_next = ident_next + 32'd1;
        end
        outs = {outs, r};
      end
      stsu_pkg::CMD_REMOVE: begin
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && tbl_ident[i] == it.target_ident) begin
            tbl_valid[i] = 1'b0;
            found = 1'b1;
          end
        r.kind = stsu_pkg::KIND_REMOVE;
        r.ok = found;
        r.last = 1'b1;
        outs = {outs, r};
      end
      stsu_pkg::CMD_TICK: begin
        tick_now = tick_now + 32'd1;
        for (int i = 0; i < SLOTS; i++) begin
          age[i] = tick_now - tbl_expiry[i];
          due[i] = tbl_valid[i] && !age[i][31];
        end
        forever begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++)
            if (due[i] && (pick < 0 || age[i] > age[pick] ||
                (age[i] == age[pick] && tbl_ident[i] < tbl_ident[pick])))
              pick = i;
          if (pick < 0) break;
          due[pick] = 1'b0;
          r = '0;
          r.kind = stsu_pkg::KIND_EXPIRED;
          r.timer_ref = tbl_ident[pick];
          outs = {outs, r};
          if (tbl_periodic[pick]) tbl_expiry[pick] = tick_now + 32'(tbl_period[pick]);
          else tbl_valid[pick] = 1'b0;
        end
        if (outs.size() == 0) begin
          r = '0;
          r.kind = stsu_pkg::KIND_IDLE_TICK;
          outs = {outs, r};
        end
        outs[outs.size()-1].last = 1'b1;
      end
      default: ;
    endcase
    act = '0;
    for (int i = 0; i < SLOTS; i++) act = act + 5'(tbl_valid[i]);
    ttn = ticks_left();
    foreach (outs[k]) begin
      outs[k].active_count = act;
      outs[k].time_to_next = ttn;
      expected_results = {expected_results, outs[k]};
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_timers(item);
        items_sent++;
      end
      if (start && busy) begin
        // hold until the transfer happens
      end else if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (result.kind == stsu_pkg::KIND_EXPIRED) expiries_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d ref=%0d", result.kind, result.timer_ref);
        fail_count++;
      end else begin : cmp
        stsu_pkg::result_t e;
        e = expected_results.pop_front();
        if (result.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, result.kind); fail_count++;
        end
        if (result.timer_ref !== e.timer_ref) begin
          $error("timer_ref exp %0d got %0d", e.timer_ref, result.timer_ref); fail_count++;
        end
        if (result.ok !== e.ok) begin
          $error("ok exp %0d got %0d", e.ok, result.ok); fail_count++;
        end
        if (result.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, result.last); fail_count++;
        end
        if (result.active_count !== e.active_count) begin
          $error("active_count exp %0d got %0d", e.active_count, result.active_count);
          fail_count++;
        end
        if (result.time_to_next !== e.time_to_next) begin
          $error("time_to_next exp %0d got %0d", e.time_to_next, result.time_to_next);
          fail_count++;
        end
      end
    end
  end

  // watchdog: count cycles with no transfer in either direction
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("software_timer_scheduler_unit: mismatch");
      $finish;
    end
  end

  function automatic stsu_pkg::item_t make_item(logic [1:0] c, logic [23:0] d, logic rp,
                                                logic [31:0] t);
    stsu_pkg::item_t it;
    it.cmd = c;
    it.duration = d;
    it.repeating = rp;
    it.target_ident = t;
    return it;
  endfunction

  function automatic stsu_pkg::item_t random_item();
    int sel;
    sel = int'($urandom_range(99));
    if (sel < 35)
      return make_item(stsu_pkg::CMD_ADD, ($urandom_range(9) == 0) ? 24'($urandom) :
                       24'($urandom_range(6)), 1'($urandom_range(1)), $urandom);
    if (sel < 50)
      return make_item(stsu_pkg::CMD_REMOVE, 24'($urandom), 1'($urandom_range(1)),
                       ($urandom_range(3) == 0) ? $urandom : $urandom_range(40));
    if (sel < 97)
      return make_item(stsu_pkg::CMD_TICK, 24'($urandom), 1'($urandom_range(1)), $urandom);
    return make_item(stsu_pkg::CMD_NONE, 24'($urandom), 1'($urandom_range(1)), $urandom);
  endfunction

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_expiry[i] = '0;
      tbl_period[i] = '0;
      tbl_periodic[i] = 1'b0;
      tbl_ident[i] = '0;
    end
    tick_now = '0;
    ident_next = 32'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, zero-period periodic, ties, full table, remove, max duration
    pending_items = {pending_items, make_item(stsu_pkg::CMD_TICK, 24'd0, 1'b0, 32'd0)};
    pending_items = {pending_items, make_item(stsu_pkg::CMD_ADD, 24'd0, 1'b1, 32'd0)};
    pending_items = {pending_items,
                     make_item(stsu_pkg::CMD_ADD, 24'hFFFFFF, 1'b0, 32'hFFFFFFFF)};
    for (int i = 0; i < 15; i++)
      pending_items = {pending_items, make_item(stsu_pkg::CMD_ADD, 24'd2, 1'(i % 2), 32'd0)};
    pending_items = {pending_items, make_item(stsu_pkg::CMD_TICK, 24'd0, 1'b0, 32'd0)};
    pending_items = {pending_items, make_item(stsu_pkg::CMD_TICK, 24'd0, 1'b0, 32'd0)};
    pending_items = {pending_items, make_item(stsu_pkg::CMD_REMOVE, 24'd0, 1'b0, 32'd2)};
    pending_items = {pending_items, make_item(stsu_pkg::CMD_REMOVE, 24'd0, 1'b0, 32'd2)};
    pending_items = {pending_items,
                     make_item(stsu_pkg::CMD_REMOVE, 24'd0, 1'b0, 32'hFFFFFFFF)};
    pending_items = {pending_items,
                     make_item(stsu_pkg::CMD_NONE, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF)};
    pending_items = {pending_items, make_item(stsu_pkg::CMD_TICK, 24'd0, 1'b0, 32'd0)};
    for (int i = 0; i < 200; i++) begin
      calm = (i >= 80 && i < 120);
      pending_items = {pending_items, random_item()};
      while (pending_items.size() > 4) @(posedge clk);
    end
    calm = 1'b0;
    while (pending_items.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    $display("covered %0d commands, %0d results, %0d timer expiries",
             items_sent, results_seen, expiries_seen);
    if (fail_count == 0) $display("software_timer_scheduler_unit: match");
    else $display("software_timer_scheduler_unit: mismatch");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/stsu_pkg.sv
rtl/stsu_cell.sv
rtl/software_timer_scheduler_unit.sv
tb/software_timer_scheduler_unit_test.sv
